// ===== rtl/core/vfa_pkg.sv =====
// Shared types, constants and saturation helpers for the Q16.16 vector ALU.
`default_nettype none

package vfa_pkg;

  localparam int SQ_STAGES = 32;
  localparam int DV_BITS = 17;
  localparam int DV_STAGES = DV_BITS + 1;

  localparam logic signed [67:0] QMAX = 68'sd2147483647;
  localparam logic signed [67:0] QMIN = -68'sd2147483648;
  localparam logic signed [67:0] HALF_WIDE = 68'sd32768;
  localparam logic signed [65:0] HALF_LANE = 66'sd32768;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_LERP  = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5,
    OP_MAG   = 3'd6,
    OP_NORM  = 3'd7
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [2:0][31:0] r;
    logic [31:0]      so;
    logic             sat;
  } side_t;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic [31:0]      so;
    logic             zm;
    logic             sat;
  } res_t;

  function automatic logic ovf32(input logic signed [67:0] v);
    return (v > QMAX) || (v < QMIN);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [67:0] v);
    if (v > QMAX) begin
      return 32'h7FFF_FFFF;
    end else if (v < QMIN) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vfa_sqrt.sv =====
// Pipelined rounded square root, one root bit per stage, with a passing sideband.
`default_nettype none

module vfa_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_rad,
  input  vfa_pkg::side_t in_side,
  output logic          out_valid,
  output logic [32:0]   out_root,
  output vfa_pkg::side_t out_side
);
  import vfa_pkg::*;

  logic        vld  [SQ_STAGES];
  logic [65:0] rem  [SQ_STAGES];
  logic [31:0] root [SQ_STAGES];
  side_t       side [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    localparam int K = SQ_STAGES - 1 - g;
    logic [65:0] rem_in;
    logic [65:0] trial;
    logic [31:0] root_in;
    logic        vld_in;
    side_t       side_in;

    if (g == 0) begin : g_first
      assign rem_in  = {2'b00, in_rad};
      assign root_in = '0;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem[g-1];
      assign root_in = root[g-1];
      assign vld_in  = vld[g-1];
      assign side_in = side[g-1];
    end

    assign trial = ({34'd0, root_in} << (K + 1)) | (66'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[g] <= side_in;
        if (rem_in >= trial) begin
          rem[g]  <= rem_in - trial;
          root[g] <= root_in | (32'd1 << K);
        end else begin
          rem[g]  <= rem_in;
          root[g] <= root_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side[SQ_STAGES-1];
      out_root <= {1'b0, root[SQ_STAGES-1]}
                + {32'd0, (rem[SQ_STAGES-1] > {34'd0, root[SQ_STAGES-1]})};
    end
  end

  // The floor root leaves a remainder no larger than twice the root.
  assert property (@(posedge clk) disable iff (rst)
    vld[SQ_STAGES-1] |-> rem[SQ_STAGES-1] <= {33'd0, root[SQ_STAGES-1], 1'b0})
    else $error("square root remainder out of range");

endmodule

`default_nettype wire

// ===== rtl/core/vfa_div.sv =====
// Pipelined normalize divider: a setup stage, then one quotient bit per stage, and the final result register.
`default_nettype none

module vfa_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [32:0]    in_root,
  input  vfa_pkg::side_t in_side,
  output logic           out_valid,
  output vfa_pkg::res_t  out_res
);
  import vfa_pkg::*;

  logic        vld  [DV_STAGES];
  logic [50:0] rem  [DV_STAGES][3];
  logic [16:0] quo  [DV_STAGES][3];
  logic [2:0]  neg  [DV_STAGES];
  logic [33:0] dvs  [DV_STAGES];
  logic [32:0] mag  [DV_STAGES];
  side_t       side [DV_STAGES];
  logic [50:0] num  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {{2{in_side.r[i][31]}}, in_side.r[i], 17'd0} + {18'd0, in_root};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= num[i] ^ {51{num[i][50]}};
        quo[0][i] <= '0;
        neg[0][i] <= num[i][50];
      end
      dvs[0]  <= {in_root, 1'b0};
      mag[0]  <= in_root;
      side[0] <= in_side;
    end
  end

  for (genvar g = 1; g < DV_STAGES; g++) begin : g_stage
    localparam int K = DV_BITS - g;
    logic [50:0] trial;

    assign trial = {17'd0, dvs[g-1]} << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem[g-1][i] >= trial) begin
            rem[g][i] <= rem[g-1][i] - trial;
            quo[g][i] <= quo[g-1][i] | (17'd1 << K);
          end else begin
            rem[g][i] <= rem[g-1][i];
            quo[g][i] <= quo[g-1][i];
          end
        end
        neg[g]  <= neg[g-1];
        dvs[g]  <= dvs[g-1];
        mag[g]  <= mag[g-1];
        side[g] <= side[g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (side[DV_STAGES-1].op)
        OP_NORM: begin
          for (int i = 0; i < 3; i++) begin
            out_res.r[i] <= (mag[DV_STAGES-1] == '0) ? '0
                          : ({15'd0, quo[DV_STAGES-1][i]} ^ {32{neg[DV_STAGES-1][i]}});
          end
          out_res.so  <= '0;
          out_res.zm  <= (mag[DV_STAGES-1] == '0);
          out_res.sat <= 1'b0;
        end
        OP_MAG: begin
          out_res.r   <= '0;
          out_res.so  <= (mag[DV_STAGES-1][32] | mag[DV_STAGES-1][31]) ? 32'h7FFF_FFFF
                       : mag[DV_STAGES-1][31:0];
          out_res.zm  <= 1'b0;
          out_res.sat <= mag[DV_STAGES-1][32] | mag[DV_STAGES-1][31];
        end
        default: begin
          out_res.r   <= side[DV_STAGES-1].r;
          out_res.so  <= side[DV_STAGES-1].so;
          out_res.zm  <= 1'b0;
          out_res.sat <= side[DV_STAGES-1].sat;
        end
      endcase
    end
  end

  // For a normalize the quotient always fits, so every lane ends below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    vld[DV_STAGES-1] && side[DV_STAGES-1].op == OP_NORM && mag[DV_STAGES-1] != '0
    |-> rem[DV_STAGES-1][0] < {17'd0, dvs[DV_STAGES-1]}
     && rem[DV_STAGES-1][1] < {17'd0, dvs[DV_STAGES-1]}
     && rem[DV_STAGES-1][2] < {17'd0, dvs[DV_STAGES-1]})
    else $error("normalize quotient overflow");

endmodule

`default_nettype wire

// ===== rtl/core/vec3_fixed_point_alu.sv =====
// Top level of the three-component Q16.16 vector ALU: front arithmetic and stream ports.
// An accepted input transaction passes through six arithmetic stages, then the 33-stage
// square root and the 19-stage normalize divider, before its output transaction.
// Throughput is one transaction per cycle while the output is taken.
// Reset is synchronous and clears only the valid bits; the payload is not reset.
`default_nettype none

module vec3_fixed_point_alu (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  input  logic [223:0] s_axis_tdata,
  // op
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r_x, r_y, r_z, scalar_out
  output logic [127:0] m_axis_tdata,
  // zero_magnitude, saturated
  output logic [1:0]   m_axis_tuser
);
  import vfa_pkg::*;

  logic en;
  logic va, vb, vc, vd, ve, vf;

  op_t               a_op;
  logic signed [31:0] a_av [3];
  logic signed [31:0] a_bv [3];
  logic signed [31:0] a_s;

  logic signed [32:0] x0 [3];
  logic signed [31:0] y0 [3];
  logic signed [31:0] x1 [3];
  logic signed [31:0] y1 [3];
  logic signed [32:0] sum [3];

  op_t                b_op;
  logic signed [31:0] b_a  [3];
  logic signed [32:0] b_sum [3];
  logic signed [32:0] b_x0 [3];
  logic signed [31:0] b_y0 [3];
  logic signed [31:0] b_x1 [3];
  logic signed [31:0] b_y1 [3];

  op_t                c_op;
  logic signed [31:0] c_a  [3];
  logic signed [32:0] c_sum [3];
  logic signed [64:0] c_p0 [3];
  logic signed [63:0] c_p1 [3];

  op_t                d_op;
  logic signed [31:0] d_a  [3];
  logic signed [32:0] d_sum [3];
  logic signed [65:0] d_c  [3];
  logic signed [65:0] d_dot2;
  logic signed [64:0] d_p2;

  op_t                e_op;
  logic signed [31:0] e_a  [3];
  logic signed [32:0] e_sum [3];
  logic signed [49:0] e_rnd [3];
  logic signed [65:0] e_dot;
  logic signed [65:0] rnd_t [3];

  logic signed [67:0] lane_v [3];
  logic signed [67:0] so_v;
  side_t              f_next;
  side_t              f_side;
  logic [63:0]        f_rad;

  logic               sq_valid;
  logic [32:0]        sq_root;
  side_t              sq_side;
  res_t               res;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else if (en) begin
      va <= s_axis_tvalid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op <= op_t'(s_axis_tuser);
      for (int i = 0; i < 3; i++) begin
        a_av[i] <= s_axis_tdata[32*i +: 32];
        a_bv[i] <= s_axis_tdata[96 + 32*i +: 32];
      end
      a_s <= s_axis_tdata[223:192];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x0[i] = 33'(a_av[i]);
      y0[i] = a_av[i];
      x1[i] = '0;
      y1[i] = '0;
      sum[i] = (a_op == OP_SUB) ? 33'(a_av[i]) - 33'(a_bv[i])
                                : 33'(a_av[i]) + 33'(a_bv[i]);
    end
    case (a_op)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          y0[i] = a_s;
        end
      end
      OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          x0[i] = 33'(a_bv[i]) - 33'(a_av[i]);
          y0[i] = a_s;
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          y0[i] = a_bv[i];
        end
      end
      OP_CROSS: begin
        x0[0] = 33'(a_av[1]);
        y0[0] = a_bv[2];
        x1[0] = a_av[2];
        y1[0] = a_bv[1];
        x0[1] = 33'(a_av[2]);
        y0[1] = a_bv[0];
        x1[1] = a_av[0];
        y1[1] = a_bv[2];
        x0[2] = 33'(a_av[0]);
        y0[2] = a_bv[1];
        x1[2] = a_av[1];
        y1[2] = a_bv[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op <= a_op;
      for (int i = 0; i < 3; i++) begin
        b_a[i]   <= a_av[i];
        b_sum[i] <= sum[i];
        b_x0[i]  <= x0[i];
        b_y0[i]  <= y0[i];
        b_x1[i]  <= x1[i];
        b_y1[i]  <= y1[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_op <= b_op;
      for (int i = 0; i < 3; i++) begin
        c_a[i]   <= b_a[i];
        c_sum[i] <= b_sum[i];
        c_p0[i]  <= 65'(b_x0[i]) * 65'(b_y0[i]);
        c_p1[i]  <= 64'(b_x1[i]) * 64'(b_y1[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_op <= c_op;
      for (int i = 0; i < 3; i++) begin
        d_a[i]   <= c_a[i];
        d_sum[i] <= c_sum[i];
        d_c[i]   <= (c_op == OP_CROSS) ? 66'(c_p0[i]) - 66'(c_p1[i]) : 66'(c_p0[i]);
      end
      d_dot2 <= 66'(c_p0[0]) + 66'(c_p0[1]);
      d_p2   <= c_p0[2];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_t[i] = d_c[i] + HALF_LANE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_op <= d_op;
      for (int i = 0; i < 3; i++) begin
        e_a[i]   <= d_a[i];
        e_sum[i] <= d_sum[i];
        e_rnd[i] <= rnd_t[i][65:16];
      end
      e_dot <= d_dot2 + 66'(d_p2);
    end
  end

  always_comb begin
    so_v = '0;
    for (int i = 0; i < 3; i++) begin
      lane_v[i] = '0;
    end
    case (e_op)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          lane_v[i] = 68'(e_sum[i]);
        end
      end
      OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          lane_v[i] = 68'(e_rnd[i]);
        end
      end
      OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          lane_v[i] = 68'(e_a[i]) + 68'(e_rnd[i]);
        end
      end
      OP_DOT: begin
        so_v = (68'(e_dot) + HALF_WIDE) >>> 16;
      end
      default: begin
      end
    endcase
    f_next.op  = e_op;
    f_next.so  = sat32(so_v);
    f_next.sat = ovf32(so_v);
    for (int i = 0; i < 3; i++) begin
      f_next.r[i] = (e_op == OP_NORM) ? e_a[i] : sat32(lane_v[i]);
      f_next.sat  = f_next.sat | ovf32(lane_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side <= f_next;
      f_rad  <= e_dot[63:0];
    end
  end

  vfa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vf),
    .in_rad   (f_rad),
    .in_side  (f_side),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  vfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_valid),
    .in_root  (sq_root),
    .in_side  (sq_side),
    .out_valid(m_axis_tvalid),
    .out_res  (res)
  );

  assign m_axis_tdata = {res.so, res.r[2], res.r[1], res.r[0]};
  assign m_axis_tuser = {res.sat, res.zm};

  // A zero-vector normalize returns an all-zero result and never saturates.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("zero magnitude with nonzero result");

endmodule

`default_nettype wire

// ===== sim/vec3_fixed_point_alu_tb.sv =====
// Self-checking Q16.16 vector ALU testbench: directed and random jobs against a predictor.
`timescale 1ns / 1ps

module vec3_fixed_point_alu_tb;
  import vfa_pkg::*;

  typedef struct {
    op_t op;
    logic [31:0] a [3];
    logic [31:0] b [3];
    logic [31:0] s;
  } vec_job_t;

  typedef struct {
    logic [31:0] r [3];
    logic [31:0] so;
    logic zm;
    logic sat;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  vec_job_t pending_jobs [$];
  vec_res_t expected_results [$];
  int errors = 0;
  int results_seen = 0;
  int ops_sent [8];
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  vec3_fixed_point_alu dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [127:0] floor_div(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if ((n % d != 0) && (n < 0)) q = q - 1;
    return q;
  endfunction

  // Round-half-up of a value with 16 fraction bits.
  function automatic logic signed [127:0] round_q(input logic signed [127:0] p);
    return (p + 128'sd32768) >>> 16;
  endfunction

  function automatic logic [31:0] clamp_q(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] round_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (n > res) res = res + 1;
    return res;
  endfunction

  function automatic vec_res_t predict_vector_op(input vec_job_t j);
    vec_res_t e;
    logic signed [127:0] a [3];
    logic signed [127:0] b [3];
    logic signed [127:0] s;
    logic signed [127:0] r [3];
    logic signed [127:0] so;
    logic signed [127:0] m;
    logic [63:0] sq;
    logic sat;
    int k;
    int p;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(j.a[i]);
      b[i] = $signed(j.b[i]);
      r[i] = 0;
    end
    s = $signed(j.s);
    so = 0;
    sat = 1'b0;
    e.zm = 1'b0;
    case (j.op)
      OP_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_q(a[i] * s);
      OP_LERP: for (int i = 0; i < 3; i++) r[i] = a[i] + round_q((b[i] - a[i]) * s);
      OP_DOT: so = round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          k = (i + 1) % 3;
          p = (i + 2) % 3;
          r[i] = round_q(a[k] * b[p] - a[p] * b[k]);
        end
      end
      default: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + 64'(a[i] * a[i]);
        m = {64'd0, round_sqrt(sq)};
        if (j.op == OP_MAG) begin
          so = m;
        end else if (m == 0) begin
          e.zm = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) r[i] = floor_div(2 * a[i] * 65536 + m, 2 * m);
        end
      end
    endcase
    for (int i = 0; i < 3; i++) e.r[i] = clamp_q(r[i], sat);
    e.so = clamp_q(so, sat);
    e.sat = sat;
    return e;
  endfunction

  function automatic logic [31:0] rand_q(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 8) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      3: return 32'($signed($urandom_range(0, 400)) - 200);
      default: return 32'($signed($urandom_range(0, 65536 * 600)) - 65536 * 300);
    endcase
  endfunction

  task automatic push_job(input op_t op, input logic [31:0] ax, input logic [31:0] ay,
                          input logic [31:0] az, input logic [31:0] bx,
                          input logic [31:0] by, input logic [31:0] bz,
                          input logic [31:0] s);
    vec_job_t j;
    j.op = op;
    j.a[0] = ax; j.a[1] = ay; j.a[2] = az;
    j.b[0] = bx; j.b[1] = by; j.b[2] = bz;
    j.s = s;
    pending_jobs.push_back(j);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ops_sent[s_axis_tuser] = ops_sent[s_axis_tuser] + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_jobs.size() > 0) begin
          vec_job_t j;
          j = pending_jobs.pop_front();
          expected_results.push_back(predict_vector_op(j));
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= j.op;
          s_axis_tdata <= {j.s, j.b[2], j.b[1], j.b[0], j.a[2], j.a[1], j.a[0]};
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        vec_res_t e;
        logic [31:0] got [4];
        results_seen = results_seen + 1;
        for (int i = 0; i < 4; i++) got[i] = m_axis_tdata[32 * i +: 32];
        if (expected_results.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result %h / %b", $time, m_axis_tdata, m_axis_tuser);
        end else begin
          e = expected_results.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got[i] !== e.r[i]) begin
              errors = errors + 1;
              $display("%0t: r[%0d] expected %h actual %h", $time, i, e.r[i], got[i]);
            end
          end
          if (got[3] !== e.so) begin
            errors = errors + 1;
            $display("%0t: scalar_out expected %h actual %h", $time, e.so, got[3]);
          end
          if (m_axis_tuser[0] !== e.zm) begin
            errors = errors + 1;
            $display("%0t: zero_magnitude expected %b actual %b", $time, e.zm,
                     m_axis_tuser[0]);
          end
          if (m_axis_tuser[1] !== e.sat) begin
            errors = errors + 1;
            $display("%0t: saturated expected %b actual %b", $time, e.sat, m_axis_tuser[1]);
          end
        end
      end
      stall_phase = (stall_phase + 1) % 200;
      if (stall_phase < 60) m_axis_tready <= 1'b1;
      else if (stall_phase < 120) m_axis_tready <= ($urandom_range(0, 3) != 0);
      else m_axis_tready <= (stall_phase % 7) > 2;
    end
  end

  initial begin
    int mode;
    int idle;
    push_job(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
             32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0);
    push_job(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0);
    push_job(OP_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0, 32'h0, 32'h0,
             32'h0000_8000);
    push_job(OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
             32'h8000_0000);
    push_job(OP_LERP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h0001_0000, 32'h0001_0000);
    push_job(OP_LERP, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0,
             32'h0003_0000, 32'h7FFF_FFFF);
    push_job(OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    push_job(OP_DOT, 32'h0000_0001, 32'h0, 32'h0, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
    push_job(OP_CROSS, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    push_job(OP_CROSS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    push_job(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_job(OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_job(OP_MAG, 32'h0000_0003, 32'h0000_0004, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_job(OP_NORM, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'hFFFF_FFFF);
    push_job(OP_NORM, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_job(OP_NORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_job(OP_NORM, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    for (int n = 0; n < 1400; n++) begin
      mode = $urandom_range(0, 4);
      push_job(op_t'($urandom_range(0, 7)), rand_q(mode), rand_q(mode), rand_q(mode),
               rand_q(mode), rand_q(mode), rand_q(mode), rand_q($urandom_range(0, 4)));
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_jobs.size() == 0 && expected_results.size() == 0);
    idle = 0;
    while (idle < 200) begin
      @(posedge clk);
      idle = idle + 1;
    end
    $display("Checked %0d results; ops add..norm: %0d %0d %0d %0d %0d %0d %0d %0d",
             results_seen, ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3],
             ops_sent[4], ops_sent[5], ops_sent[6], ops_sent[7]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout after 5 ms");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
